/* src/vlsu_pkg.sv */
`timescale 1ns / 1ps

package vlsu_pkg;

	localparam int LANES_DEF         = 4;
	localparam int REGFILE_WORDS_DEF = 128;
	localparam int OUT_LANES         = 4;
	localparam int MAX_ROWS          = 32;

	localparam logic [6:0] OPC_VLOAD  = 7'b0000111;
	localparam logic [6:0] OPC_VSTORE = 7'b0100111;
	localparam logic [6:0] OPC_OPV    = 7'b1010111;
	localparam logic [2:0] WIDTH_E32  = 3'b110;
	localparam logic [2:0] F3_IVV     = 3'b000;
	localparam logic [2:0] F3_MVV     = 3'b010;
	localparam logic [5:0] F6_ADD     = 6'b000000;
	localparam logic [5:0] F6_SUB     = 6'b000010;
	localparam logic [5:0] F6_MUL     = 6'b100101;

	typedef struct packed {
		logic [31:0] instruction;
		logic [31:0] base_address;
		logic [31:0] load_word0;
		logic [31:0] load_word1;
		logic [31:0] load_word2;
		logic [31:0] load_word3;
	} cmd_item_t;

	typedef struct packed {
		logic        halted;
		logic        register_written;
		logic [4:0]  dest_register;
		logic        store_valid;
		logic [29:0] word_address;
		logic [31:0] lane0_value;
		logic [31:0] lane1_value;
		logic [31:0] lane2_value;
		logic [31:0] lane3_value;
	} result_item_t;

endpackage

/* src/vlsu_chan_if.sv */
`timescale 1ns / 1ps

interface vlsu_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* src/vlsu_ram.sv */
`timescale 1ns / 1ps

module vlsu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/vector_lane_alu_load_store_unit.sv */
`timescale 1ns / 1ps

// Vector unit for a subset of the vector extension: unit-stride vle32/vse32 and lane-wise
// vadd.vv, vsub.vv and vmul.vv (low 32 bits) over 32 registers of LANES 32-bit elements.
// One instruction is taken per cycle unless the result port stalls; each gives one result.
// The register file sits in two mirrored row-wide RAMs (one row per register, one read port
// each for the two source operands); the read lands in the execute stage, which also does the
// lane-wise add/sub/multiply and writes the row back, and a bypass of the last written row
// covers a dependence on the instruction right before. Rows reset to zero through per-row valid
// flops, so there is no clearing pass after reset. Words beyond REGFILE_WORDS read as zero;
// only lanes 0..3 appear in the result.
module vector_lane_alu_load_store_unit
	import vlsu_pkg::*;
#(
	parameter int LANES         = LANES_DEF,
	parameter int REGFILE_WORDS = REGFILE_WORDS_DEF
) (
	input logic clk,
	input logic arst_n,
	vlsu_chan_if.sink   cmd,
	vlsu_chan_if.source result
);

	localparam int ROWS_RAW = (REGFILE_WORDS + LANES - 1) / LANES;
	localparam int ROWS     = (ROWS_RAW > MAX_ROWS) ? MAX_ROWS : ROWS_RAW;
	localparam int AW       = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int RW       = LANES * 32;
	localparam int EXT      = (LANES > OUT_LANES) ? LANES : OUT_LANES;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_HALT,
		OP_LOAD,
		OP_STORE,
		OP_ADD,
		OP_SUB,
		OP_MUL
	} op_t;

	// decode of the incoming instruction
	op_t        dec_op;
	logic [4:0] dec_addr_a;
	logic [4:0] dec_addr_b;
	logic       cmd_xfer;
	logic       s1_adv;

	// execute stage
	logic        s1_valid_q;
	op_t         op_s1;
	logic [4:0]  rd_s1;
	logic [4:0]  addr_a_s1;
	logic [4:0]  addr_b_s1;
	logic [29:0] waddr_s1;
	logic [OUT_LANES-1:0][31:0] ldw_s1;

	// register file
	logic [ROWS-1:0] row_valid_q;
	logic            lastwr_vld_q;
	logic [4:0]      lastwr_row_q;
	logic [RW-1:0]   lastwr_data_q;
	logic [RW-1:0]   ram_a_rdata;
	logic [RW-1:0]   ram_b_rdata;
	logic            wr_en;
	logic [RW-1:0]   wr_data;

	logic [EXT-1:0][31:0] opa;
	logic [EXT-1:0][31:0] opb;
	logic [EXT-1:0][31:0] res;
	logic [EXT-1:0][31:0] ldv;
	logic [EXT-1:0][31:0] lane_out;
	logic                 writes;

	logic         out_valid_q;
	result_item_t out_q;
	result_item_t out_d;

	assign s1_adv    = !out_valid_q || result.ready;
	assign cmd.ready = !s1_valid_q || s1_adv;
	assign cmd_xfer  = cmd.valid && cmd.ready;

	always_comb begin
		logic [31:0] ins;
		logic        unit32;
		ins    = cmd.payload.instruction;
		unit32 = (ins[14:12] == WIDTH_E32) && (ins[27:26] == 2'b00) && (ins[24:20] == 5'd0);
		dec_op = OP_HALT;
		if (ins[6:0] == OPC_VLOAD && unit32) begin
			dec_op = OP_LOAD;
		end else if (ins[6:0] == OPC_VSTORE && unit32) begin
			dec_op = OP_STORE;
		end else if (ins[6:0] == OPC_OPV && ins[14:12] == F3_IVV) begin
			if (ins[31:26] == F6_ADD) begin
				dec_op = OP_ADD;
			end else if (ins[31:26] == F6_SUB) begin
				dec_op = OP_SUB;
			end else begin
				dec_op = OP_NONE;
			end
		end else if (ins[6:0] == OPC_OPV && ins[14:12] == F3_MVV) begin
			dec_op = (ins[31:26] == F6_MUL) ? OP_MUL : OP_NONE;
		end
		// port a carries vs2, or vs3 for a store
		dec_addr_a = (dec_op == OP_STORE) ? ins[11:7] : ins[24:20];
		dec_addr_b = ins[19:15];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (cmd.ready) begin
			s1_valid_q <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			op_s1     <= dec_op;
			rd_s1     <= cmd.payload.instruction[11:7];
			addr_a_s1 <= dec_addr_a;
			addr_b_s1 <= dec_addr_b;
			waddr_s1  <= cmd.payload.base_address[31:2];
			ldw_s1[0] <= cmd.payload.load_word0;
			ldw_s1[1] <= cmd.payload.load_word1;
			ldw_s1[2] <= cmd.payload.load_word2;
			ldw_s1[3] <= cmd.payload.load_word3;
		end
	end

	vlsu_ram #(.WIDTH(RW), .DEPTH(ROWS)) u_ram_a (
		.clk   (clk),
		.we    (wr_en),
		.waddr (rd_s1[AW-1:0]),
		.wdata (wr_data),
		.re    (cmd_xfer),
		.raddr (dec_addr_a[AW-1:0]),
		.rdata (ram_a_rdata)
	);

	vlsu_ram #(.WIDTH(RW), .DEPTH(ROWS)) u_ram_b (
		.clk   (clk),
		.we    (wr_en),
		.waddr (rd_s1[AW-1:0]),
		.wdata (wr_data),
		.re    (cmd_xfer),
		.raddr (dec_addr_b[AW-1:0]),
		.rdata (ram_b_rdata)
	);

	// operand fetch with bypass of the row written at the read edge
	always_comb begin
		logic [RW-1:0] row_a;
		logic [RW-1:0] row_b;
		row_a = '0;
		row_b = '0;
		if (lastwr_vld_q && lastwr_row_q == addr_a_s1) begin
			row_a = lastwr_data_q;
		end else if (int'(addr_a_s1) < ROWS && row_valid_q[addr_a_s1[AW-1:0]]) begin
			row_a = ram_a_rdata;
		end
		if (lastwr_vld_q && lastwr_row_q == addr_b_s1) begin
			row_b = lastwr_data_q;
		end else if (int'(addr_b_s1) < ROWS && row_valid_q[addr_b_s1[AW-1:0]]) begin
			row_b = ram_b_rdata;
		end
		opa = '0;
		opb = '0;
		for (int l = 0; l < LANES; l++) begin
			// words past the end of the file read as zero
			if (int'(addr_a_s1) * LANES + l < REGFILE_WORDS) begin
				opa[l] = row_a[l*32 +: 32];
			end
			if (int'(addr_b_s1) * LANES + l < REGFILE_WORDS) begin
				opb[l] = row_b[l*32 +: 32];
			end
		end
	end

	always_comb begin
		res = '0;
		ldv = '0;
		for (int l = 0; l < LANES; l++) begin
			unique case (op_s1)
				OP_ADD:  res[l] = opa[l] + opb[l];
				OP_SUB:  res[l] = opa[l] - opb[l];
				OP_MUL:  res[l] = opa[l] * opb[l];
				default: res[l] = '0;
			endcase
		end
		for (int l = 0; l < LANES && l < OUT_LANES; l++) begin
			ldv[l] = ldw_s1[l];
		end
	end

	always_comb begin
		writes = (op_s1 == OP_LOAD) || (op_s1 == OP_ADD) || (op_s1 == OP_SUB)
			|| (op_s1 == OP_MUL);
		wr_en  = s1_valid_q && s1_adv && writes && (int'(rd_s1) < ROWS);
		for (int l = 0; l < LANES; l++) begin
			wr_data[l*32 +: 32] = (op_s1 == OP_LOAD) ? ldv[l] : res[l];
		end
	end

	always_comb begin
		out_d    = '0;
		lane_out = '0;
		unique case (op_s1)
			OP_HALT: begin
				out_d.halted = 1'b1;
			end
			OP_NONE: begin
			end
			OP_LOAD: begin
				out_d.register_written = 1'b1;
				out_d.dest_register    = rd_s1;
				out_d.word_address     = waddr_s1;
				lane_out               = ldv;
			end
			OP_STORE: begin
				out_d.store_valid   = 1'b1;
				out_d.dest_register = rd_s1;
				out_d.word_address  = waddr_s1;
				lane_out            = opa;
			end
			default: begin
				out_d.register_written = 1'b1;
				out_d.dest_register    = rd_s1;
				lane_out               = res;
			end
		endcase
		out_d.lane0_value = lane_out[0];
		out_d.lane1_value = lane_out[1];
		out_d.lane2_value = lane_out[2];
		out_d.lane3_value = lane_out[3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q  <= '0;
			lastwr_vld_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				row_valid_q[rd_s1[AW-1:0]] <= 1'b1;
				lastwr_vld_q               <= 1'b1;
			end
			if (s1_adv) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			lastwr_row_q  <= rd_s1;
			lastwr_data_q <= wr_data;
		end
		if (s1_adv && s1_valid_q) begin
			out_q <= out_d;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	a_wr_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> row_valid_q[$past(rd_s1[AW-1:0])] && lastwr_row_q == $past(rd_s1))
		else $error("row write did not mark the row or update the bypass");

	a_halt_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.payload.halted
			|-> !result.payload.register_written && !result.payload.store_valid)
		else $error("halted result carries a write or store");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_xfer && s1_valid_q |-> s1_adv)
		else $error("transfer into a stalled execute stage");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && s1_adv |=> out_valid_q)
		else $error("executed instruction left no result");

endmodule
